// ===== src/bloom_filter_insert_query_macros.svh =====
`ifndef BLOOM_FILTER_INSERT_QUERY_MACROS_SVH
`define BLOOM_FILTER_INSERT_QUERY_MACROS_SVH

// Same-cycle implication, disabled in reset
`define BFIQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define BFIQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bfiq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfiq_pkg;

  localparam int MAX_BITS   = 65536;
  localparam int MAX_PROBES = 16;

  localparam int BIT_AW  = $clog2(MAX_BITS);
  localparam int CNT_W   = BIT_AW + 1;
  localparam int ROW_W   = 16;
  localparam int ROW_SEL = $clog2(ROW_W);
  localparam int ROW_AW  = BIT_AW - ROW_SEL;
  localparam int ROWS    = MAX_BITS / ROW_W;

  localparam int BIT_COUNT_W  = 17;
  localparam int HASH_COUNT_W = 5;

  localparam logic [31:0] HASH_SEED = 32'd5381;
  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;

  localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST  = BIT_COUNT_W'(10240);
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = HASH_COUNT_W'(7);

  localparam logic REG_BIT_COUNT  = 1'b0;
  localparam logic REG_HASH_COUNT = 1'b1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] key_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic was_query;
    logic maybe_present;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/bloom_filter_insert_query.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bloom filter, insert and query, djb2 hash with double hashing. Key bytes
// come in one item each; a byte that is not the last only updates the
// running hash. The last byte of a key occupies the block for the accepting
// cycle, the divide-by-ten multiply, the bit-serial remainder unit (h1, then
// h2), a read and a check of the single-port bit store per probe (write-back
// on inserts), and the load of the result register. A result waits in an
// output register while new key bytes are taken; the next key end holds in
// its done state until that result is taken. After reset the bit store is
// swept clear, all 4096 rows, with in_ready low; register writes are taken
// during the sweep. Registers: bit_count at 0x0, hash_count at 0x4.

`include "bloom_filter_insert_query_macros.svh"

module bloom_filter_insert_query (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire bfiq_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output bfiq_pkg::out_item_t   out_data,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [2:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_DIV1,
    S_DIV2,
    S_PRB_RD,
    S_PRB_CHK,
    S_DONE
  } state_t;

  state_t                                  state_r;
  logic [bfiq_pkg::BIT_COUNT_W-1:0]        bit_count_r;
  logic [bfiq_pkg::HASH_COUNT_W-1:0]       hash_count_r;
  logic [31:0]                             running_hash_r;
  logic [bfiq_pkg::ROW_AW-1:0]             clr_cnt_r;

  logic [31:0]                             h_r;
  logic                                    op_r;
  logic [bfiq_pkg::CNT_W-1:0]              m_r;
  logic [bfiq_pkg::HASH_COUNT_W-1:0]       k_r;
  logic [63:0]                             prod_r;
  logic [31:0]                             x_r;
  logic [31:0]                             div_q_r;
  logic [bfiq_pkg::BIT_AW-1:0]             rem_r;
  logic [4:0]                              div_cnt_r;
  logic [bfiq_pkg::BIT_AW-1:0]             h1_r;
  logic [bfiq_pkg::BIT_AW-1:0]             h2_r;
  logic [bfiq_pkg::BIT_AW-1:0]             p_r;
  logic [bfiq_pkg::HASH_COUNT_W-1:0]       prb_cnt_r;
  logic                                    all_set_r;
  logic                                    out_valid_r;
  bfiq_pkg::out_item_t                     out_data_r;

  logic [bfiq_pkg::ROW_W-1:0]              bits_mem [bfiq_pkg::ROWS];
  logic [bfiq_pkg::ROW_W-1:0]              rd_row_r;

  logic                                    in_acc;
  logic                                    cfg_wr;
  logic [31:0]                             hash_nxt;
  logic [bfiq_pkg::CNT_W-1:0]              m_nxt;
  logic [bfiq_pkg::HASH_COUNT_W-1:0]       k_nxt;
  logic [28:0]                             quot10;
  logic [31:0]                             x_nxt;
  logic [31:0]                             mag_nxt;
  logic [bfiq_pkg::CNT_W-1:0]              div_shift;
  logic [bfiq_pkg::BIT_AW-1:0]             rem_nxt;
  logic [bfiq_pkg::CNT_W-1:0]              p_sum;
  logic [bfiq_pkg::BIT_AW-1:0]             p_nxt;
  logic [bfiq_pkg::HASH_COUNT_W-1:0]       prb_cnt_nxt;
  logic [bfiq_pkg::ROW_AW-1:0]             row_sel;
  logic                                    bit_hit;
  logic                                    out_free;
  logic                                    mem_we;
  logic [bfiq_pkg::ROW_AW-1:0]             mem_waddr;
  logic [bfiq_pkg::ROW_W-1:0]              mem_wdata;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    unique case (paddr[2])
      bfiq_pkg::REG_BIT_COUNT:  prdata = 32'(bit_count_r);
      bfiq_pkg::REG_HASH_COUNT: prdata = 32'(hash_count_r);
      default:                  prdata = '0;
    endcase
  end

  assign hash_nxt = (running_hash_r << 5) + running_hash_r + 32'(in_data.key_byte);

  always_comb begin
    if (bit_count_r == '0) begin
      m_nxt = bfiq_pkg::CNT_W'(1);
    end else if (32'(bit_count_r) > 32'(bfiq_pkg::MAX_BITS)) begin
      m_nxt = bfiq_pkg::CNT_W'(bfiq_pkg::MAX_BITS);
    end else begin
      m_nxt = bfiq_pkg::CNT_W'(bit_count_r);
    end
    if (32'(hash_count_r) > 32'(bfiq_pkg::MAX_PROBES)) begin
      k_nxt = bfiq_pkg::HASH_COUNT_W'(bfiq_pkg::MAX_PROBES);
    end else begin
      k_nxt = hash_count_r;
    end
  end

  assign quot10  = prod_r[63:35];
  assign x_nxt   = 32'({quot10, 5'b0}) - 32'(quot10);
  assign mag_nxt = x_r[31] ? (~x_r + 32'd1) : x_r;

  assign div_shift = {rem_r, div_q_r[31]};
  assign rem_nxt   = (div_shift >= m_r) ? bfiq_pkg::BIT_AW'(div_shift - m_r)
                                        : div_shift[bfiq_pkg::BIT_AW-1:0];

  assign p_sum = {1'b0, p_r} + {1'b0, h2_r};
  assign p_nxt = (p_sum >= m_r) ? bfiq_pkg::BIT_AW'(p_sum - m_r)
                                : p_sum[bfiq_pkg::BIT_AW-1:0];

  assign prb_cnt_nxt = prb_cnt_r + bfiq_pkg::HASH_COUNT_W'(1);
  assign row_sel     = p_r[bfiq_pkg::BIT_AW-1:bfiq_pkg::ROW_SEL];
  assign bit_hit     = rd_row_r[p_r[bfiq_pkg::ROW_SEL-1:0]];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_sel;
    mem_wdata = rd_row_r | (bfiq_pkg::ROW_W'(1) << p_r[bfiq_pkg::ROW_SEL-1:0]);
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (state_r == S_PRB_CHK && op_r == bfiq_pkg::OP_INSERT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bits_mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_PRB_RD) begin
      rd_row_r <= bits_mem[row_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      running_hash_r <= bfiq_pkg::HASH_SEED;
      bit_count_r    <= bfiq_pkg::BIT_COUNT_RST;
      hash_count_r   <= bfiq_pkg::HASH_COUNT_RST;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          bfiq_pkg::REG_BIT_COUNT:  bit_count_r  <= pwdata[bfiq_pkg::BIT_COUNT_W-1:0];
          bfiq_pkg::REG_HASH_COUNT: hash_count_r <= pwdata[bfiq_pkg::HASH_COUNT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + bfiq_pkg::ROW_AW'(1);
          if (clr_cnt_r == bfiq_pkg::ROW_AW'(bfiq_pkg::ROWS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.last_byte) begin
              running_hash_r <= bfiq_pkg::HASH_SEED;
              h_r            <= hash_nxt;
              op_r           <= in_data.operation;
              m_r            <= m_nxt;
              k_r            <= k_nxt;
              state_r        <= S_MUL;
            end else begin
              running_hash_r <= hash_nxt;
            end
          end
        end
        S_MUL: begin
          prod_r    <= 64'(h_r) * 64'(bfiq_pkg::RECIP10);
          div_q_r   <= h_r;
          rem_r     <= '0;
          div_cnt_r <= '0;
          state_r   <= S_DIV1;
        end
        S_DIV1: begin
          x_r       <= x_nxt;
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'd31) begin
            h1_r    <= rem_nxt;
            div_q_r <= mag_nxt;
            rem_r   <= '0;
            state_r <= S_DIV2;
          end else begin
            div_q_r <= div_q_r << 1;
            rem_r   <= rem_nxt;
          end
        end
        S_DIV2: begin
          div_q_r   <= div_q_r << 1;
          rem_r     <= rem_nxt;
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'd31) begin
            h2_r      <= rem_nxt;
            p_r       <= h1_r;
            prb_cnt_r <= '0;
            all_set_r <= 1'b1;
            state_r   <= (k_r == '0) ? S_DONE : S_PRB_RD;
          end
        end
        S_PRB_RD: begin
          state_r <= S_PRB_CHK;
        end
        S_PRB_CHK: begin
          all_set_r <= all_set_r && bit_hit;
          p_r       <= p_nxt;
          prb_cnt_r <= prb_cnt_nxt;
          state_r   <= (prb_cnt_nxt == k_r) ? S_DONE : S_PRB_RD;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r              <= 1'b1;
            out_data_r.was_query     <= op_r;
            out_data_r.maybe_present <= (op_r == bfiq_pkg::OP_QUERY) && all_set_r;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BFIQ_ASSERT_NOW(a_probe_in_range, (state_r == S_PRB_RD || state_r == S_PRB_CHK), ({1'b0, p_r} < m_r), "probe position not below bit count")
  `BFIQ_ASSERT_NOW(a_rem_in_range, (state_r == S_DIV1 || state_r == S_DIV2), ({1'b0, rem_r} < m_r), "partial remainder not below bit count")
  `BFIQ_ASSERT_NOW(a_probe_count, (state_r == S_PRB_RD || state_r == S_PRB_CHK), (prb_cnt_r < k_r), "probe count overrun")
  `BFIQ_ASSERT_NEXT(a_insert_result, (state_r == S_DONE && out_free && op_r == bfiq_pkg::OP_INSERT), (out_valid_r && !out_data_r.maybe_present && !out_data_r.was_query), "insert result not loaded as insert")

endmodule

`default_nettype wire

// ===== tb/tb_bloom_filter_insert_query.sv =====
`timescale 1ns / 1ps

module tb_bloom_filter_insert_query;
  import bfiq_pkg::*;

  localparam int DRAIN_CYCLES = 160;
  localparam int KEY_MAX = 12;
  localparam int KEY_SLOTS = 32;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 103;
  localparam int MAX_SHOWN = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bloom_filter_insert_query dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  // filter state mirror
  bit filter_copy [MAX_BITS];
  logic [31:0] key_hash = HASH_SEED;
  logic [BIT_COUNT_W-1:0] cfg_bits = BIT_COUNT_RST;
  logic [HASH_COUNT_W-1:0] cfg_probes = HASH_COUNT_RST;
  out_item_t pending_answers[$];

  int mismatches = 0;
  int burst_left = 0;
  int stall_left = 0;
  bit steady_tx = 1'b0;
  bit steady_rx = 1'b0;

  logic [7:0] key_buf [KEY_MAX];
  logic [7:0] saved_key [KEY_SLOTS][KEY_MAX];
  int saved_len [KEY_SLOTS];
  int saved_count = 0;

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t ns: %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  task automatic hash_and_probe(in_item_t it);
    logic [31:0] h, x, mag, h1, h2, m, k;
    logic [63:0] pos;
    logic all_set;
    out_item_t answer;
    key_hash = key_hash * 32'd33 + {24'd0, it.key_byte};
    if (it.last_byte) begin
      h = key_hash;
      key_hash = HASH_SEED;
      if (cfg_bits == 0)
        m = 32'd1;
      else if (cfg_bits > MAX_BITS)
        m = 32'(MAX_BITS);
      else
        m = 32'(cfg_bits);
      k = (cfg_probes > MAX_PROBES) ? 32'(MAX_PROBES) : 32'(cfg_probes);
      h1 = h % m;
      x = (h / 32'd10) * 32'd31;
      mag = x[31] ? (32'd0 - x) : x;
      h2 = mag % m;
      all_set = 1'b1;
      for (int probe = 0; probe < k; probe++) begin
        pos = (64'(h1) + 64'(probe) * 64'(h2)) % 64'(m);
        if (it.operation == OP_INSERT)
          filter_copy[pos] = 1'b1;
        else if (!filter_copy[pos])
          all_set = 1'b0;
      end
      answer.was_query = (it.operation == OP_QUERY);
      answer.maybe_present = (it.operation == OP_QUERY) && all_set;
      pending_answers.push_back(answer);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      hash_and_probe(in_data);
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, 32'(out_data));
      end else begin
        want = pending_answers.pop_front();
        if (out_data.was_query !== want.was_query)
          report_mismatch("was_query", 32'(want.was_query), 32'(out_data.was_query));
        if (out_data.maybe_present !== want.maybe_present)
          report_mismatch("maybe_present", 32'(want.maybe_present),
                          32'(out_data.maybe_present));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= !out_ready || steady_rx;
      stall_left <= (out_ready && !steady_rx) ? $urandom_range(0, 7) : $urandom_range(0, 24);
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = steady_tx ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_key(logic op, int len);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.last_byte = (i == len - 1);
      it.operation = it.last_byte ? op : 1'($urandom_range(0, 1));
      it.key_byte = key_buf[i];
      send_item(it);
    end
  endtask

  task automatic send_bytes1(logic op, logic [7:0] b0);
    key_buf[0] = b0;
    send_key(op, 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic reg_sel, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(reg_sel) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_BIT_COUNT)
      cfg_bits = value[BIT_COUNT_W-1:0];
    else
      cfg_probes = value[HASH_COUNT_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check(logic reg_sel);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'(reg_sel) << 2;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == REG_BIT_COUNT) begin
      if (got[BIT_COUNT_W-1:0] !== cfg_bits)
        report_mismatch("bit_count readback", 32'(cfg_bits), 32'(got[BIT_COUNT_W-1:0]));
    end else begin
      if (got[HASH_COUNT_W-1:0] !== cfg_probes)
        report_mismatch("hash_count readback", 32'(cfg_probes),
                        32'(got[HASH_COUNT_W-1:0]));
    end
    @(posedge clk);
  endtask

  task automatic test_reset_values();
    cfg_check(REG_BIT_COUNT);
    cfg_check(REG_HASH_COUNT);
    send_bytes1(OP_INSERT, 8'h00);
    send_bytes1(OP_QUERY, 8'h00);
    key_buf[0] = 8'hFF;
    key_buf[1] = 8'hFF;
    send_key(OP_INSERT, 2);
    send_key(OP_QUERY, 2);
    send_bytes1(OP_QUERY, 8'h41);
    settle();
  endtask

  task automatic test_probe_count_extremes();
    cfg_write(REG_HASH_COUNT, 32'd0);
    cfg_check(REG_HASH_COUNT);
    send_bytes1(OP_QUERY, 8'h5A);
    send_bytes1(OP_INSERT, 8'h5B);
    settle();
    cfg_write(REG_HASH_COUNT, 32'd16);
    send_bytes1(OP_INSERT, 8'h80);
    send_bytes1(OP_QUERY, 8'h80);
    settle();
    cfg_write(REG_HASH_COUNT, 32'hFFFF_FFFF);
    cfg_check(REG_HASH_COUNT);
    send_bytes1(OP_QUERY, 8'h7F);
    settle();
  endtask

  task automatic test_bit_count_extremes();
    cfg_write(REG_HASH_COUNT, 32'd7);
    cfg_write(REG_BIT_COUNT, 32'd0);
    send_bytes1(OP_INSERT, 8'h10);
    send_bytes1(OP_QUERY, 8'h20);
    settle();
    cfg_write(REG_BIT_COUNT, 32'd1);
    send_bytes1(OP_QUERY, 8'h33);
    settle();
    cfg_write(REG_BIT_COUNT, 32'(MAX_BITS));
    send_bytes1(OP_INSERT, 8'hC3);
    send_bytes1(OP_QUERY, 8'hC3);
    settle();
    cfg_write(REG_BIT_COUNT, 32'hFFFF_FFFF);
    cfg_check(REG_BIT_COUNT);
    send_bytes1(OP_QUERY, 8'hC3);
    settle();
  endtask

  task automatic test_config_mid_key();
    in_item_t it;
    key_buf[0] = 8'h12;
    key_buf[1] = 8'h34;
    key_buf[2] = 8'h56;
    for (int i = 0; i < 2; i++) begin
      it.operation = 1'($urandom_range(0, 1));
      it.key_byte = key_buf[i];
      it.last_byte = 1'b0;
      send_item(it);
    end
    settle();
    cfg_write(REG_BIT_COUNT, 32'd4096);
    cfg_write(REG_HASH_COUNT, 32'd3);
    it.operation = OP_INSERT;
    it.key_byte = key_buf[2];
    it.last_byte = 1'b1;
    send_item(it);
    send_key(OP_QUERY, 3);
    settle();
  endtask

  task automatic pick_phase_config();
    case ($urandom_range(0, 5))
      0: cfg_write(REG_BIT_COUNT, 32'($urandom_range(8, 256)));
      1: cfg_write(REG_BIT_COUNT, 32'($urandom_range(1, MAX_BITS)));
      2: cfg_write(REG_BIT_COUNT, 32'(MAX_BITS));
      3: cfg_write(REG_BIT_COUNT, 32'($urandom_range(0, 1)));
      4: cfg_write(REG_BIT_COUNT, $urandom());
      default: cfg_write(REG_BIT_COUNT, 32'($urandom_range(1000, 12000)));
    endcase
    if ($urandom_range(0, 4) == 0)
      cfg_write(REG_HASH_COUNT, 32'($urandom_range(0, 31)));
    else
      cfg_write(REG_HASH_COUNT, 32'($urandom_range(1, MAX_PROBES)));
  endtask

  task automatic run_random_phase(int n_items);
    in_item_t it;
    int sent, len, slot;
    logic op;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        it.operation = 1'($urandom_range(0, 1));
        it.key_byte = 8'($urandom_range(0, 255));
        it.last_byte = ($urandom_range(0, 3) == 0);
        send_item(it);
        sent++;
      end else begin
        op = $urandom_range(0, 1) ? OP_QUERY : OP_INSERT;
        if (op == OP_QUERY && saved_count != 0 && $urandom_range(0, 2) != 0) begin
          slot = $urandom_range(0, ((saved_count < KEY_SLOTS) ? saved_count : KEY_SLOTS) - 1);
          len = saved_len[slot];
          for (int i = 0; i < len; i++) key_buf[i] = saved_key[slot][i];
        end else begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, KEY_MAX) : $urandom_range(1, 4);
          for (int i = 0; i < len; i++) key_buf[i] = 8'($urandom_range(0, 255));
        end
        if (op == OP_INSERT) begin
          slot = saved_count % KEY_SLOTS;
          saved_len[slot] = len;
          for (int i = 0; i < len; i++) saved_key[slot][i] = key_buf[i];
          saved_count++;
        end
        send_key(op, len);
        sent += len;
      end
    end
    settle();
  endtask

  task automatic test_random_keys();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady_tx = (ph % 4 == 1);
      steady_rx = (ph % 3 == 2);
      pick_phase_config();
      run_random_phase(PHASE_ITEMS);
    end
    steady_tx = 1'b0;
    steady_rx = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_probe_count_extremes();
    test_bit_count_extremes();
    test_config_mid_key();
    test_random_keys();
    settle();
    if (pending_answers.size() != 0)
      report_mismatch("results never produced", 32'd0, 32'(pending_answers.size()));
    if (mismatches == 0)
      $display("bloom_filter_insert_query test passed");
    else
      $display("bloom_filter_insert_query test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("bloom_filter_insert_query test failed");
    $finish;
  end

endmodule
